FILE: rtl/crcrx_pkg.sv
// Shared types, codes and the CRC-16 byte update for the frame receiver.
`default_nettype none

package crcrx_pkg;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [16:0] TICKS_MAX = 17'h1FFFF;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_HDR2 = 3'd1,
        PH_TYPE = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_CRCL = 3'd5,
        PH_CRCH = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_DATA = 3'd0,
        ST_GOOD = 3'd1,
        ST_CRC  = 3'd2,
        ST_HDR  = 3'd3,
        ST_LEN  = 3'd4,
        ST_TIME = 3'd5
    } status_t;

    localparam logic [1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD   = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd3;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_type;
        logic [7:0] frame_length;
        logic       last;
    } result_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/crcrx_core.sv
// Frame parsing state machine with configuration registers and CRC check.
`default_nettype none

module crcrx_core
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_fire,
    input  wire logic              command,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              cfg_write,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    output logic                   res_valid,
    output crcrx_pkg::result_t     res
);
    import crcrx_pkg::*;

    logic [7:0]  header_first_reg;
    logic [7:0]  header_second_reg;
    logic [7:0]  max_payload_reg;
    logic [15:0] timeout_ticks_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [16:0] ticks_reg, ticks_next;

    logic [15:0] crc_upd;
    logic [16:0] ticks_inc;
    status_t     res_status;
    logic [7:0]  res_data;
    logic [7:0]  res_index;
    logic        res_last;

    assign crc_upd = crc_update(crc_reg, rx_byte);
    assign ticks_inc = (ticks_reg < TICKS_MAX) ? ticks_reg + 17'd1 : ticks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= 8'd170;
            header_second_reg <= 8'd85;
            max_payload_reg   <= 8'd64;
            timeout_ticks_reg <= 16'd100;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HEADER_FIRST:  header_first_reg  <= cfg_data[7:0];
                CFG_HEADER_SECOND: header_second_reg <= cfg_data[7:0];
                CFG_MAX_PAYLOAD:   max_payload_reg   <= cfg_data[7:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            crc_reg     <= CRC_INIT;
            type_reg    <= 8'd0;
            length_reg  <= 8'd0;
            count_reg   <= 8'd0;
            crc_low_reg <= 8'd0;
            ticks_reg   <= 17'd0;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
            type_reg    <= type_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            crc_low_reg <= crc_low_next;
            ticks_reg   <= ticks_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        crc_next     = crc_reg;
        type_next    = type_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        crc_low_next = crc_low_reg;
        ticks_next   = ticks_reg;
        res_valid    = 1'b0;
        res_status   = ST_DATA;
        res_data     = 8'd0;
        res_index    = 8'd0;
        res_last     = 1'b0;

        if (command == CMD_TICK)
        begin
            if (phase_reg != PH_HUNT)
            begin
                ticks_next = ticks_inc;
                if (ticks_inc > {1'b0, timeout_ticks_reg})
                begin
                    res_valid  = in_fire;
                    res_status = ST_TIME;
                    res_last   = 1'b1;
                    phase_next = PH_HUNT;
                    ticks_next = 17'd0;
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == header_first_reg)
                    begin
                        crc_next     = CRC_INIT;
                        type_next    = 8'd0;
                        length_next  = 8'd0;
                        count_next   = 8'd0;
                        crc_low_next = 8'd0;
                        phase_next   = PH_HDR2;
                        ticks_next   = 17'd0;
                    end
                end
                PH_HDR2:
                begin
                    ticks_next = 17'd0;
                    if (rx_byte != header_second_reg)
                    begin
                        res_valid  = in_fire;
                        res_status = ST_HDR;
                        res_last   = 1'b1;
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_next  = rx_byte;
                    crc_next   = crc_upd;
                    phase_next = PH_LEN;
                    ticks_next = 17'd0;
                end
                PH_LEN:
                begin
                    length_next = rx_byte;
                    crc_next    = crc_upd;
                    ticks_next  = 17'd0;
                    if (rx_byte > max_payload_reg)
                    begin
                        res_valid  = in_fire;
                        res_status = ST_LEN;
                        res_last   = 1'b1;
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        count_next = 8'd0;
                        phase_next = (rx_byte == 8'd0) ? PH_CRCL : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    crc_next   = crc_upd;
                    count_next = count_reg + 8'd1;
                    if (count_next >= length_reg)
                    begin
                        phase_next = PH_CRCL;
                        ticks_next = 17'd0;
                    end
                    res_valid  = in_fire;
                    res_status = ST_DATA;
                    res_data   = rx_byte;
                    res_index  = count_reg;
                end
                PH_CRCL:
                begin
                    crc_low_next = rx_byte;
                    phase_next   = PH_CRCH;
                    ticks_next   = 17'd0;
                end
                PH_CRCH:
                begin
                    res_valid  = in_fire;
                    res_status = ({rx_byte, crc_low_reg} == crc_reg) ? ST_GOOD : ST_CRC;
                    res_last   = 1'b1;
                    phase_next = PH_HUNT;
                    ticks_next = 17'd0;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    ticks_next = 17'd0;
                end
            endcase
        end
    end

    always_comb
    begin
        res.status       = res_status;
        res.data_byte    = res_data;
        res.byte_index   = res_index;
        res.frame_type   = type_next;
        res.frame_length = length_next;
        res.last         = res_last;
    end

endmodule

`default_nettype wire

FILE: rtl/crcrx_outbuf.sv
// Output register with a skid stage that decouples the result channel.
`default_nettype none

module crcrx_outbuf
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire crcrx_pkg::result_t push_data,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output crcrx_pkg::result_t     out_data
);
    import crcrx_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop       = main_valid_reg && !out_stall;
    assign in_stall  = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (push)
            begin
                main_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/crc_checked_frame_receiver_unit.sv
// Top level of the CRC-checked frame receiver.
// The request channel carries one received byte (command low) or one time
// tick (command high) per accepted request, with in_valid and in_stall.
// Each accepted request updates the frame parser in the same cycle and
// yields at most one result: a payload byte as it arrives, or a verdict
// with last set (good frame, CRC error, header error, length error or
// timeout). Results leave through out_valid and out_stall.
// A result is registered in the output register, or in the skid stage if
// that is full, before out_valid shows it. The block takes one request
// per cycle while in_stall is low; the CRC byte update is combinational.
// The output register is backed by a skid stage, so a stalled receiver
// costs nothing until both hold a result; only then is in_stall raised.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data, by the user only while the block is idle; the block does not
// enforce this. Reset clears the parser to hunting for the first header
// byte, loads the register defaults and empties the output stages.
`default_nettype none

module crc_checked_frame_receiver_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        command,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [7:0]       data_byte,
    output logic [7:0]       byte_index,
    output logic [7:0]       frame_type,
    output logic [7:0]       frame_length,
    output logic             last,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import crcrx_pkg::*;

    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t out_data;

    assign in_fire = in_valid && !in_stall;

    crcrx_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .command   (command),
        .rx_byte   (rx_byte),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    crcrx_outbuf u_outbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign status       = out_data.status;
    assign data_byte    = out_data.data_byte;
    assign byte_index   = out_data.byte_index;
    assign frame_type   = out_data.frame_type;
    assign frame_length = out_data.frame_length;
    assign last         = out_data.last;

endmodule

`default_nettype wire
